/* rtl/pfba_pkg.sv */
// pfba_pkg: shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package pfba_pkg;

  localparam int unsigned MAP_WORDS_DEF = 1024;
  localparam int unsigned BITS_PER_WORD = 32;
  localparam int unsigned PAGE_LIMIT = 32768;
  localparam int unsigned PAGE_W = 15;
  localparam int unsigned COUNT_W = 16;
  // page index of a range end: first_page + page_count
  localparam int unsigned END_W = 17;
  // word index derived from a range end
  localparam int unsigned RWORD_W = END_W - 5;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic scan_rd;
    logic scan_adv;
    logic alloc_wr;
    logic alloc_fail;
    logic rng_rd;
    logic rng_step;
    logic rng_err;
    logic push;
  } pfba_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       hint_end;
    logic       next_end;
    logic       word_full;
    logic       rng_bad;
    logic       rng_empty;
    logic       rng_last;
    logic       out_free;
  } pfba_sts_t;

endpackage

/* rtl/pfba_ctrl.sv */
// pfba_ctrl: sequencer for clearing, allocation scan and range marking
`timescale 1ns / 1ps

module pfba_ctrl
  import pfba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  pfba_sts_t sts,
  output pfba_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_CHK,
    S_RANGE_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd) inside
          CMD_ALLOC: begin
            if (sts.hint_end) begin
              cmd.alloc_fail = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.scan_rd = 1'b1;
              state_next = S_ALLOC_CHK;
            end
          end
          CMD_FREE, CMD_RESERVE: begin
            if (sts.rng_bad) begin
              cmd.rng_err = 1'b1;
              state_next = S_DONE;
            end else if (sts.rng_empty) begin
              state_next = S_DONE;
            end else begin
              cmd.rng_rd = 1'b1;
              state_next = S_RANGE_WR;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ALLOC_CHK: begin
        if (!sts.word_full) begin
          cmd.alloc_wr = 1'b1;
          state_next = S_DONE;
        end else if (sts.next_end) begin
          cmd.alloc_fail = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_RANGE_WR: begin
        // write this word and fetch the next one in the same cycle
        cmd.rng_step = 1'b1;
        if (sts.rng_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed while output register busy");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.load)
    else $error("item taken during clearing pass");

endmodule

/* rtl/pfba_datapath.sv */
// pfba_datapath: bitmap memory, scan hint, range walker and result register
`timescale 1ns / 1ps

module pfba_datapath
  import pfba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pfba_cmd_t           cmd,
  output pfba_sts_t           sts,
  input  logic [1:0]          cmd_in,
  input  logic [PAGE_W-1:0]   first_page,
  input  logic [COUNT_W-1:0]  page_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PAGE_W-1:0]   page_number,
  output logic [1:0]          status
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SCAN_WORDS =
    (MAP_WORDS < PAGE_LIMIT / BITS_PER_WORD) ? MAP_WORDS : PAGE_LIMIT / BITS_PER_WORD;
  localparam int unsigned HW = $clog2(SCAN_WORDS + 1);
  localparam int unsigned TOTAL_PAGES = MAP_WORDS * BITS_PER_WORD;

  logic [31:0] mem [MAP_WORDS];
  logic [31:0] rdata;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic [AW-1:0]       clr_cnt;
  logic [HW-1:0]       hint;
  logic [1:0]          cmd_q;
  logic [PAGE_W-1:0]   first_q;
  logic [COUNT_W-1:0]  count_q;
  logic [RWORD_W-1:0]  rng_ptr;
  logic [PAGE_W-1:0]   res_page;
  logic [1:0]          res_status;

  logic [END_W-1:0]    rng_end;
  logic [END_W-1:0]    last_page;
  logic [RWORD_W-1:0]  first_w;
  logic [RWORD_W-1:0]  last_w;
  logic [4:0]          lo_bit;
  logic [4:0]          hi_bit;
  logic [31:0]         mask;
  logic [4:0]          free_bit;

  // range decode from the latched item
  assign rng_end   = END_W'(first_q) + END_W'(count_q);
  assign last_page = rng_end - END_W'(1);
  assign first_w   = RWORD_W'(first_q[PAGE_W-1:5]);
  assign last_w    = last_page[END_W-1:5];
  assign lo_bit    = (rng_ptr == first_w) ? first_q[4:0] : 5'd0;
  assign hi_bit    = (rng_ptr == last_w) ? last_page[4:0] : 5'd31;
  assign mask      = (ALL_ONES << lo_bit) & (ALL_ONES >> (5'd31 - hi_bit));

  // lowest clear bit of the fetched word
  always_comb begin
    free_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!rdata[i]) free_bit = 5'(i);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(hint);
    wr_en   = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end
    if (cmd.scan_rd) begin
      rd_en = 1'b1;
    end
    if (cmd.scan_adv) begin
      rd_en   = 1'b1;
      rd_addr = AW'(hint + HW'(1));
    end
    if (cmd.alloc_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(hint);
      wr_data = rdata | (32'd1 << free_bit);
    end
    if (cmd.rng_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(rng_ptr);
    end
    if (cmd.rng_step) begin
      rd_en   = 1'b1;
      rd_addr = AW'(rng_ptr + RWORD_W'(1));
      wr_en   = 1'b1;
      wr_addr = AW'(rng_ptr);
      wr_data = (cmd_q == CMD_RESERVE) ? (rdata | mask) : (rdata & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hint    <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.alloc_fail) begin
        hint <= HW'(SCAN_WORDS);
      end else if (cmd.scan_adv) begin
        hint <= hint + HW'(1);
      end else if (cmd.rng_step && cmd_q == CMD_FREE && rng_ptr < RWORD_W'(hint)) begin
        // freed word below the hint: scanning must start there again
        hint <= HW'(rng_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q      <= cmd_in;
      first_q    <= first_page;
      count_q    <= page_count;
      rng_ptr    <= RWORD_W'(first_page[PAGE_W-1:5]);
      res_page   <= '0;
      res_status <= ST_OK;
    end
    if (cmd.rng_step) rng_ptr <= rng_ptr + RWORD_W'(1);
    if (cmd.alloc_wr) res_page <= PAGE_W'({hint, free_bit});
    if (cmd.alloc_fail) res_status <= ST_NO_FREE;
    if (cmd.rng_err) res_status <= ST_RANGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      page_number <= res_page;
      status      <= res_status;
    end
  end

  assign sts.clr_last  = (clr_cnt == AW'(MAP_WORDS - 1));
  assign sts.cmd       = cmd_q;
  assign sts.hint_end  = (hint == HW'(SCAN_WORDS));
  assign sts.next_end  = (hint == HW'(SCAN_WORDS - 1));
  assign sts.word_full = (rdata == ALL_ONES);
  assign sts.rng_bad   = (32'(rng_end) > 32'(TOTAL_PAGES));
  assign sts.rng_empty = (count_q == '0);
  assign sts.rng_last  = (rng_ptr == last_w);
  assign sts.out_free  = !out_valid || !out_stall;

  a_alloc_has_free: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_wr |-> (rdata != ALL_ONES))
    else $error("allocation written into a full word");

  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hint) <= 32'(SCAN_WORDS))
    else $error("scan hint past the end");

  a_range_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.rng_step |-> (!sts.rng_bad && !sts.rng_empty))
    else $error("range walk on a rejected range");

endmodule

/* rtl/page_frame_bitmap_allocator_top.sv */
// Allocate scans from the scan hint, skipping full words
//   (the lowest word that may hold a clear bit); free or reserve walks each bitmap
//   word the range touches, one memory read and write each cycle.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous; a clearing pass then writes all MAP_WORDS words to zero, one per
//   cycle, and in_stall stays high until the pass is done.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_top
  import pfba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [PAGE_W-1:0]  first_page,
  input  logic [COUNT_W-1:0] page_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PAGE_W-1:0]  page_number,
  output logic [1:0]         status
);

  pfba_cmd_t ctl_cmd;
  pfba_sts_t dp_sts;

  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  pfba_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl_cmd),
    .sts         (dp_sts),
    .cmd_in      (cmd),
    .first_page  (first_page),
    .page_count  (page_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .page_number (page_number),
    .status      (status)
  );

endmodule

/* test/testbench.sv */
// testbench for the first-fit page frame bitmap allocator: scoreboard class plus driving tasks
`timescale 1ns / 1ps

module testbench;
  import pfba_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [1:0]        status;
  } frame_reply_t;

  class frame_alloc_tracker;
    logic [31:0]  frame_map [MAP_WORDS_DEF];
    frame_reply_t expected_replies [$];
    int           errors;

    function new();
      foreach (frame_map[i]) frame_map[i] = '0;
      errors = 0;
    endfunction

    function frame_reply_t predict(logic [1:0] op, logic [PAGE_W-1:0] first,
                                   logic [COUNT_W-1:0] count);
      frame_reply_t r;
      int unsigned  limit;
      int unsigned  range_end;
      int unsigned  p;
      int unsigned  w;
      int unsigned  b;
      bit           found;
      r.page = '0;
      r.status = ST_OK;
      limit = MAP_WORDS_DEF * BITS_PER_WORD;
      if (limit > PAGE_LIMIT) limit = PAGE_LIMIT;
      case (op) inside
        CMD_ALLOC: begin
          found = 0;
          for (w = 0; w * BITS_PER_WORD < limit && !found; w++) begin
            if (frame_map[w] != ALL_ONES) begin
              for (b = 0; b < BITS_PER_WORD && !found; b++) begin
                p = w * BITS_PER_WORD + b;
                if (p < limit && !frame_map[w][b]) begin
                  frame_map[w][b] = 1'b1;
                  r.page = p[PAGE_W-1:0];
                  found = 1;
                end
              end
            end
          end
          if (!found) r.status = ST_NO_FREE;
        end
        CMD_FREE, CMD_RESERVE: begin
          range_end = int'(first) + int'(count);
          if (range_end > MAP_WORDS_DEF * BITS_PER_WORD) begin
            r.status = ST_RANGE;
          end else begin
            for (p = first; p < range_end; p++)
              frame_map[p / BITS_PER_WORD][p % BITS_PER_WORD] = (op == CMD_RESERVE);
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void take_request(logic [1:0] op, logic [PAGE_W-1:0] first,
                               logic [COUNT_W-1:0] count);
      expected_replies.push_back(predict(op, first, count));
    endfunction

    function void check_reply(logic [PAGE_W-1:0] page, logic [1:0] st);
      frame_reply_t exp;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result page_number %0d status %0d", $time, page, st);
        errors++;
        return;
      end
      exp = expected_replies.pop_front();
      if (page !== exp.page) begin
        $display("%0t: page_number expected %0d actual %0d", $time, exp.page, page);
        errors++;
      end
      if (st !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_replies.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [PAGE_W-1:0]  first_page;
  logic [COUNT_W-1:0] page_count;
  logic               out_valid;
  logic               out_stall;
  logic [PAGE_W-1:0]  page_number;
  logic [1:0]         status;

  frame_alloc_tracker tracker;
  bit                 steady = 1'b0;
  int unsigned        items_sent = 0;

  page_frame_bitmap_allocator_top #(
    .MAP_WORDS(MAP_WORDS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .first_page(first_page),
    .page_count(page_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .page_number(page_number),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("page_frame_bitmap_allocator_top: mismatch");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input int unsigned first,
                           input int unsigned count);
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    first_page <= first[PAGE_W-1:0];
    page_count <= count[COUNT_W-1:0];
    do @(posedge clk); while (in_stall);
    tracker.take_request(op, first[PAGE_W-1:0], count[COUNT_W-1:0]);
    items_sent <= items_sent + 1;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold-off once 150 items have been sent
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) tracker.check_reply(page_number, status);
      if (!hold_done && items_sent >= 150) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 13);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned first;
    int unsigned count;
    tracker = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_ALLOC;
    first_page <= '0;
    page_count <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 0, 1);
    send_item(CMD_ALLOC, 0, 0);
    // empty range at the last page, then the last page alone
    send_item(CMD_FREE, 32767, 0);
    send_item(CMD_RESERVE, 32767, 1);
    send_item(CMD_FREE, 32767, 2);
    send_item(CMD_RESERVE, 0, 32768);
    // map full
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 32767, 1);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 0, 32768);
    send_item(CMD_RESERVE, 32767, 32768);
    send_item(CMD_RESERVE, 0, 31);
    send_item(CMD_ALLOC, 0, 0);
    // full words to skip
    send_item(CMD_RESERVE, 32, 64);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 16, 40);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 0, 32768);
    // range that ends exactly at the top
    send_item(CMD_RESERVE, 1, 32767);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 0, 32768);
    wait_drained();

    for (int n = 0; n < 700; n++) begin
      if (n == 250) steady <= 1'b1;
      if (n == 400) begin
        steady <= 1'b0;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      first = 0;
      count = 0;
      if (pick < 45) begin
        send_item(CMD_ALLOC, 0, 0);
      end else if (pick < 65) begin
        first = $urandom_range(0, 2047);
        send_item(CMD_FREE, first, $urandom_range(0, 40));
      end else if (pick < 75) begin
        first = $urandom_range(0, 2047);
        send_item(CMD_RESERVE, first, $urandom_range(0, 20));
      end else if (pick < 83) begin
        first = $urandom_range(0, 32767);
        count = $urandom_range(0, (32768 - first) < 40 ? 32768 - first : 40);
        send_item(pick[0] ? CMD_FREE : CMD_RESERVE, first, count);
      end else if (pick < 90) begin
        // range past the end
        first = $urandom_range(1, 32767);
        count = $urandom_range(32769 - first, 32768);
        send_item(pick[0] ? CMD_FREE : CMD_RESERVE, first, count);
      end else if (pick == 90) begin
        send_item(CMD_FREE, 0, 32768);
      end else if (pick == 91) begin
        first = $urandom_range(0, 32767);
        send_item(CMD_RESERVE, first, 32768 - first);
      end else if (pick == 92) begin
        send_item(CMD_RESERVE, 0, 32768);
      end else begin
        send_item(CMD_ALLOC, 0, 0);
      end
    end

    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("page_frame_bitmap_allocator_top: match");
    end else begin
      $display("page_frame_bitmap_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pfba_pkg.sv
rtl/pfba_ctrl.sv
rtl/pfba_datapath.sv
rtl/page_frame_bitmap_allocator_top.sv
test/testbench.sv
